// ===== hdl/spcd_pkg.sv =====
// spcd_pkg: shared types and constants of the stroke point clip/decimate block
// holds the payload structs, the configuration register map and the fixed field widths
// no dependencies
package spcd_pkg;

	// field widths fixed by the interface
	localparam int COORD_W    = 20;
	localparam int EXTENT_W   = 19;
	localparam int GAP_W      = 16;
	localparam int SCALE_W    = 28;
	localparam int SID_W      = 32;
	localparam int UM_W       = 32;

	// shared multiplier and wide intermediates
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int MAG_W      = 20;                  // |dx|, |dy|, |x|, |y|
	localparam int SS_W       = 2 * MAG_W + 1;       // dx^2 + dy^2
	localparam int USQ_W      = 2 * SCALE_W;         // um_per_px^2
	localparam int LHS_W      = SS_W + USQ_W;        // (dx^2 + dy^2) * um_per_px^2

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	localparam logic [SCALE_W-1:0] UM_PER_PX_RST = 28'd1083733;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEL_EN      = 3'd0,
		REG_RECT_LEFT   = 3'd1,
		REG_RECT_TOP    = 3'd2,
		REG_RECT_WIDTH  = 3'd3,
		REG_RECT_HEIGHT = 3'd4,
		REG_GAP_UM      = 3'd5,
		REG_UM_PER_PX   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                       sel_en;
		logic signed [COORD_W-1:0]  rect_left;
		logic signed [COORD_W-1:0]  rect_top;
		logic [EXTENT_W-1:0]        rect_width;
		logic [EXTENT_W-1:0]        rect_height;
		logic [GAP_W-1:0]           gap_um;
		logic [SCALE_W-1:0]         um_per_px;
	} spcd_cfg_t;

	typedef struct packed {
		logic                       stroke_start;
		logic [SID_W-1:0]           stroke_id;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
	} spcd_in_t;

	typedef struct packed {
		logic [SID_W-1:0]           out_stroke_id;
		logic                       first_in_stroke;
		logic signed [UM_W-1:0]     x_um;
		logic signed [UM_W-1:0]     y_um;
	} spcd_out_t;

endpackage

// ===== hdl/spcd_mul.sv =====
// spcd_mul: shared 32x32 unsigned multiplier with registered product
// depends on spcd_pkg
module spcd_mul (
	input  logic                         clk,
	input  logic [spcd_pkg::MUL_W-1:0]   a,
	input  logic [spcd_pkg::MUL_W-1:0]   b,
	output logic [spcd_pkg::PROD_W-1:0]  prod_q
);
	import spcd_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// ===== hdl/spcd_seq.sv =====
// spcd_seq: clip test, sequencer and datapath around the shared multiplier
// depends on spcd_pkg and spcd_mul
module spcd_seq #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int SCALE_FRAC_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spcd_pkg::spcd_cfg_t    cfg,
	input  logic                   in_valid,
	input  spcd_pkg::spcd_in_t     in_data,
	output logic                   in_ready,
	output logic                   res_valid,
	input  logic                   res_ready,
	output spcd_pkg::spcd_out_t    res
);
	import spcd_pkg::*;

	localparam int SH      = COORD_FRAC_BITS + SCALE_FRAC_BITS;
	localparam int SPROD_W = MAG_W + SCALE_W;
	localparam int RHS_W   = 2 * GAP_W + 2 * SH;
	localparam int CMP_W   = (RHS_W > LHS_W) ? RHS_W : LHS_W;
	localparam logic [SPROD_W:0] HALF    = ((SPROD_W + 1)'(1) << SH) >> 1;
	localparam logic [SPROD_W:0] SAT_POS = (SPROD_W + 1)'(64'h7FFF_FFFF);
	localparam logic [SPROD_W:0] SAT_NEG = (SPROD_W + 1)'(64'h8000_0000);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;
	typedef enum logic [3:0] {
		ST_USQ, ST_DX2, ST_DY2, ST_GSQ, ST_XS,
		ST_P00, ST_P01, ST_P10, ST_P11, ST_YS, ST_CMP
	} step_t;

	state_t                     state_q;
	step_t                      step_q;
	logic                       have_kept_q;
	logic                       first_q;
	logic                       keep_q;
	logic signed [COORD_W-1:0]  last_x_q, last_y_q;

	logic signed [COORD_W-1:0]  x_q, y_q;
	logic [SID_W-1:0]           sid_q;
	logic [MAG_W-1:0]           adx_q, ady_q, amx_q, amy_q;
	logic                       negx_q, negy_q;
	logic [USQ_W-1:0]           usq_q;
	logic [SS_W-1:0]            ss_q;
	logic [2*GAP_W-1:0]         gsq_q;
	logic [LHS_W-1:0]           acc_q;
	logic [UM_W-1:0]            xum_q, yum_q;

	logic [MUL_W-1:0]           op_a, op_b;
	logic [PROD_W-1:0]          prod_q;

	logic signed [COORD_W:0]    px, py, lx, ty, hx, hy, dx, dy, ndx, ndy, npx, npy;
	logic                       in_rect, start, first;
	logic [CMP_W-1:0]           lhs_c, rhs_c;

	function automatic logic [UM_W-1:0] to_um(input logic [PROD_W-1:0] p, input logic neg);
		logic [SPROD_W:0] q;
		logic [SPROD_W:0] qn;
		logic [UM_W-1:0]  r;
		q = ({1'b0, p[SPROD_W-1:0]} + HALF) >> SH;
		if (neg) begin
			if (q > SAT_NEG) q = SAT_NEG;
			qn = -q;
			r  = qn[UM_W-1:0];
		end else begin
			if (q > SAT_POS) q = SAT_POS;
			r = q[UM_W-1:0];
		end
		return r;
	endfunction

	// clip test and distance terms from the arriving point
	always_comb begin
		px  = {in_data.point_x[COORD_W-1], in_data.point_x};
		py  = {in_data.point_y[COORD_W-1], in_data.point_y};
		lx  = {cfg.rect_left[COORD_W-1], cfg.rect_left};
		ty  = {cfg.rect_top[COORD_W-1], cfg.rect_top};
		hx  = lx + {2'b00, cfg.rect_width};
		hy  = ty + {2'b00, cfg.rect_height};
		dx  = px - {last_x_q[COORD_W-1], last_x_q};
		dy  = py - {last_y_q[COORD_W-1], last_y_q};
		ndx = -dx;
		ndy = -dy;
		npx = -px;
		npy = -py;
		in_rect = (px >= lx) && (px <= hx) && (py >= ty) && (py <= hy);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign start     = in_valid && in_ready;
	assign first     = !(have_kept_q && !in_data.stroke_start);
	assign res_valid = (state_q == S_DONE) && keep_q;

	// scaled squared spacing against gap^2 at the same binary point
	assign lhs_c = CMP_W'(acc_q);
	assign rhs_c = CMP_W'(gsq_q) << (2 * SH);

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			ST_USQ: begin op_a = MUL_W'(cfg.um_per_px); op_b = MUL_W'(cfg.um_per_px); end
			ST_DX2: begin op_a = MUL_W'(adx_q); op_b = MUL_W'(adx_q); end
			ST_DY2: begin op_a = MUL_W'(ady_q); op_b = MUL_W'(ady_q); end
			ST_GSQ: begin op_a = MUL_W'(cfg.gap_um); op_b = MUL_W'(cfg.gap_um); end
			ST_XS:  begin op_a = MUL_W'(amx_q); op_b = MUL_W'(cfg.um_per_px); end
			ST_P00: begin op_a = ss_q[MUL_W-1:0]; op_b = usq_q[MUL_W-1:0]; end
			ST_P01: begin op_a = ss_q[MUL_W-1:0]; op_b = MUL_W'(usq_q[USQ_W-1:MUL_W]); end
			ST_P10: begin op_a = MUL_W'(ss_q[SS_W-1:MUL_W]); op_b = usq_q[MUL_W-1:0]; end
			ST_P11: begin
				op_a = MUL_W'(ss_q[SS_W-1:MUL_W]);
				op_b = MUL_W'(usq_q[USQ_W-1:MUL_W]);
			end
			ST_YS:  begin op_a = MUL_W'(amy_q); op_b = MUL_W'(cfg.um_per_px); end
			ST_CMP: begin op_a = '0; op_b = '0; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	spcd_mul u_mul (
		.clk    (clk),
		.a      (op_a),
		.b      (op_b),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_USQ;
			have_kept_q <= 1'b0;
			first_q     <= 1'b0;
			keep_q      <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (in_data.stroke_start) have_kept_q <= 1'b0;
						if (cfg.sel_en && in_rect) begin
							state_q <= S_RUN;
							step_q  <= ST_USQ;
							first_q <= first;
						end
					end
				end
				S_RUN: begin
					if (step_q == ST_CMP) begin
						state_q <= S_DONE;
						keep_q  <= first_q || (lhs_c >= rhs_c);
					end else begin
						step_q <= step_t'(step_q + 4'd1);
					end
				end
				S_DONE: begin
					if (!keep_q) begin
						state_q <= S_IDLE;
					end else if (res_ready) begin
						state_q     <= S_IDLE;
						have_kept_q <= 1'b1;
						last_x_q    <= x_q;
						last_y_q    <= y_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// each step takes the product issued one step earlier
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= in_data.point_x;
			y_q    <= in_data.point_y;
			sid_q  <= in_data.stroke_id;
			adx_q  <= dx[COORD_W] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
			ady_q  <= dy[COORD_W] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
			amx_q  <= px[COORD_W] ? npx[MAG_W-1:0] : px[MAG_W-1:0];
			amy_q  <= py[COORD_W] ? npy[MAG_W-1:0] : py[MAG_W-1:0];
			negx_q <= px[COORD_W];
			negy_q <= py[COORD_W];
		end
		if (state_q == S_RUN) begin
			unique case (step_q)
				ST_USQ: ;
				ST_DX2: usq_q <= prod_q[USQ_W-1:0];
				ST_DY2: ss_q  <= prod_q[SS_W-1:0];
				ST_GSQ: ss_q  <= ss_q + prod_q[SS_W-1:0];
				ST_XS:  gsq_q <= prod_q[2*GAP_W-1:0];
				ST_P00: xum_q <= to_um(prod_q, negx_q);
				ST_P01: acc_q <= LHS_W'(prod_q);
				ST_P10: acc_q <= acc_q + (LHS_W'(prod_q) << MUL_W);
				ST_P11: acc_q <= acc_q + (LHS_W'(prod_q) << MUL_W);
				ST_YS:  acc_q <= acc_q + (LHS_W'(prod_q) << (2 * MUL_W));
				ST_CMP: yum_q <= to_um(prod_q, negy_q);
				default: ;
			endcase
		end
	end

	assign res.out_stroke_id   = sid_q;
	assign res.first_in_stroke = first_q;
	assign res.x_um            = xum_q;
	assign res.y_um            = yum_q;

endmodule

// ===== hdl/stroke_point_clip_decimate_top.sv =====
// stroke_point_clip_decimate_top: top level with configuration registers and output register
// depends on spcd_pkg and spcd_seq
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one pen point per transfer.
//   Output channel out_valid/out_ready/out_data carries one kept point per transfer.
//   The user writes configuration through cfg_we/cfg_index/cfg_data, one register per cycle,
//   only while the block is idle (the block does not check); unlisted indexes are ignored.
// Timing:
//   A point outside the selection rectangle (or with the selection disabled) is
//   finished in its transfer cycle and in_ready stays high.
//   A point inside runs the multiplier steps ST_USQ to ST_CMP; from S_DONE a kept result
//   is loaded into the output register, while a decimated one is dropped. in_ready is low
//   until S_DONE ends, so no new point is taken meanwhile, and out_valid rises as the output
//   register loads. The single 32x32 multiplier, used 10 times per point, sets this pace.
// Reset:
//   arst_n clears the sequencer, the stroke history and the output valid, and loads
//   the register defaults (selection off, scale 96 dpi).
// Stall:
//   A result waits in the output register; the next point is taken meanwhile, and
//   that point waits in its final step until the output register frees up.
module stroke_point_clip_decimate_top #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int SCALE_FRAC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [spcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spcd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  spcd_pkg::spcd_in_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output spcd_pkg::spcd_out_t               out_data
);
	import spcd_pkg::*;

	spcd_cfg_t  cfg_q;
	spcd_out_t  res;
	logic       res_valid, res_ready, load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sel_en      <= 1'b0;
			cfg_q.rect_left   <= '0;
			cfg_q.rect_top    <= '0;
			cfg_q.rect_width  <= '0;
			cfg_q.rect_height <= '0;
			cfg_q.gap_um      <= '0;
			cfg_q.um_per_px   <= UM_PER_PX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEL_EN:      cfg_q.sel_en      <= cfg_data[0];
				REG_RECT_LEFT:   cfg_q.rect_left   <= cfg_data[COORD_W-1:0];
				REG_RECT_TOP:    cfg_q.rect_top    <= cfg_data[COORD_W-1:0];
				REG_RECT_WIDTH:  cfg_q.rect_width  <= cfg_data[EXTENT_W-1:0];
				REG_RECT_HEIGHT: cfg_q.rect_height <= cfg_data[EXTENT_W-1:0];
				REG_GAP_UM:      cfg_q.gap_um      <= cfg_data[GAP_W-1:0];
				REG_UM_PER_PX:   cfg_q.um_per_px   <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	spcd_seq #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register frees up on the same cycle it transfers
	assign res_ready = !out_valid || out_ready;
	assign load      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_data <= res;
	end

endmodule

// ===== hdl/spcd_chk.sv =====
// spcd_chk: port-level checks of the stroke point clip/decimate top level, and its bind
// depends on spcd_pkg and stroke_point_clip_decimate_top
module spcd_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  spcd_pkg::spcd_out_t               out_data
);
	import spcd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// a result leaves only by a transfer
	a_drop_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without a transfer");

	// a fresh result is handed over only as the sequencer goes idle
	a_rose_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while sequencer busy");

	// no result shows with the sequencer idle the cycle after a transfer while the output is empty
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid || !in_ready)
		else $error("result appeared too early");

endmodule

bind stroke_point_clip_decimate_top spcd_chk u_spcd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
